>>> rtl/core/nfcs_pkg.sv
// Shared types, codes and result expansion for the NOR flash command sequencer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package nfcs_pkg;

  localparam int ADDR_W      = 19;
  localparam int DATA_W      = 8;
  localparam int ADDR_BITS   = 19;
  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_W      = 3;

  localparam logic [ADDR_W-1:0] UNLOCK_A = 19'h05555;
  localparam logic [ADDR_W-1:0] UNLOCK_B = 19'h02aaa;
  localparam logic [DATA_W-1:0] UNLOCK_A_DATA = 8'haa;
  localparam logic [DATA_W-1:0] UNLOCK_B_DATA = 8'h55;
  localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'ha0;
  localparam logic [DATA_W-1:0] CMD_ERASE     = 8'h80;
  localparam logic [DATA_W-1:0] CMD_CHIP      = 8'h10;
  localparam logic [DATA_W-1:0] CMD_SECTOR    = 8'h30;
  localparam logic [DATA_W-1:0] CMD_ID_ENTRY  = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT   = 8'hf0;

  typedef enum logic [2:0] {
    MODE_READ     = 3'd0,
    MODE_PROGRAM  = 3'd1,
    MODE_SECTOR   = 3'd2,
    MODE_CHIP     = 3'd3,
    MODE_ID_ENTRY = 3'd4,
    MODE_ID_EXIT  = 3'd5,
    MODE_RESPONSE = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // Bus transaction state of the sequencer.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_READ = 3'b010,
    PH_POLL = 3'b100
  } phase_e;

  // Classified work handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_ERROR,
    OP_DONE,
    OP_READ,
    OP_PROGRAM,
    OP_SECTOR,
    OP_CHIP,
    OP_ID_ENTRY,
    OP_ID_EXIT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } desc_t;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] bus_data;
    logic [DATA_W-1:0] result_data;
  } res_t;

  function automatic res_t bus_wr(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    res_t r;
    r = '{kind: KIND_WRITE, addr: a, bus_data: d, result_data: '0};
    return r;
  endfunction

  function automatic res_t bus_rd(logic [ADDR_W-1:0] a);
    res_t r;
    r = '{kind: KIND_READ, addr: a, bus_data: '0, result_data: '0};
    return r;
  endfunction

  // Number of words an operation produces.
  function automatic logic [STEP_W-1:0] op_len(op_e op);
    logic [STEP_W-1:0] n;
    unique case (op)
      OP_PROGRAM:              n = 3'd5;
      OP_SECTOR, OP_CHIP:      n = 3'd7;
      OP_ID_ENTRY, OP_ID_EXIT: n = 3'd4;
      default:                 n = 3'd1;
    endcase
    return n;
  endfunction

  // Word number step of an operation.
  function automatic res_t expand(desc_t d, logic [STEP_W-1:0] step);
    res_t r;
    r = '{kind: KIND_ERROR, addr: '0, bus_data: '0, result_data: '0};
    unique case (d.op)
      OP_ERROR: r.kind = KIND_ERROR;
      OP_DONE: begin
        r.kind        = KIND_DONE;
        r.result_data = d.data;
      end
      OP_READ: r = bus_rd(d.addr);
      OP_PROGRAM: begin
        case (step)
          3'd0:    r = bus_wr(UNLOCK_A, UNLOCK_A_DATA);
          3'd1:    r = bus_wr(UNLOCK_B, UNLOCK_B_DATA);
          3'd2:    r = bus_wr(UNLOCK_A, CMD_PROGRAM);
          3'd3:    r = bus_wr(d.addr, d.data);
          default: r = bus_rd(d.addr);
        endcase
      end
      OP_SECTOR, OP_CHIP: begin
        case (step)
          3'd0, 3'd3: r = bus_wr(UNLOCK_A, UNLOCK_A_DATA);
          3'd1, 3'd4: r = bus_wr(UNLOCK_B, UNLOCK_B_DATA);
          3'd2:       r = bus_wr(UNLOCK_A, CMD_ERASE);
          3'd5: begin
            if (d.op == OP_SECTOR) begin
              r = bus_wr(d.addr, CMD_SECTOR);
            end else begin
              r = bus_wr(UNLOCK_A, CMD_CHIP);
            end
          end
          default: r = bus_rd(d.addr);
        endcase
      end
      default: begin
        case (step)
          3'd0: r = bus_wr(UNLOCK_A, UNLOCK_A_DATA);
          3'd1: r = bus_wr(UNLOCK_B, UNLOCK_B_DATA);
          3'd2: r = bus_wr(UNLOCK_A, (d.op == OP_ID_ENTRY) ? CMD_ID_ENTRY : CMD_ID_EXIT);
          default: r.kind = KIND_DONE;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/nfcs_cmd_if.sv
// Command channel of the NOR flash command sequencer: valid/ready and one command word.
// Depends on nfcs_pkg for field widths.
interface nfcs_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  mode;
  logic [nfcs_pkg::ADDR_W-1:0] address;
  logic [nfcs_pkg::DATA_W-1:0] write_data;
  logic [nfcs_pkg::DATA_W-1:0] read_data;

  modport source (output valid, mode, address, write_data, read_data, input ready);
  modport sink   (input valid, mode, address, write_data, read_data, output ready);
endinterface

>>> rtl/core/nfcs_rsp_if.sv
// Result channel of the NOR flash command sequencer: valid/ready and one result word.
// Depends on nfcs_pkg for field widths.
interface nfcs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [nfcs_pkg::ADDR_W-1:0] bus_address;
  logic [nfcs_pkg::DATA_W-1:0] bus_data;
  logic [nfcs_pkg::DATA_W-1:0] result_data;
  logic                        last;

  modport source (output valid, kind, bus_address, bus_data, result_data, last, input ready);
  modport sink   (input valid, kind, bus_address, bus_data, result_data, last, output ready);
endinterface

>>> rtl/core/nfcs_front.sv
// Front end: accepts command words, tracks the pending bus read and classifies each word.
// Depends on nfcs_pkg and nfcs_cmd_if.
module nfcs_front #(
  parameter int AddrBits = nfcs_pkg::ADDR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nfcs_cmd_if.sink          cmd_i,
  input  logic              full_i,
  output logic              push_o,
  output nfcs_pkg::desc_t   desc_o
);

  localparam logic [nfcs_pkg::ADDR_W-1:0] AddrMask =
      nfcs_pkg::ADDR_W'((64'd1 << AddrBits) - 64'd1);

  nfcs_pkg::phase_e                phase_q, phase_d;
  logic [nfcs_pkg::ADDR_W-1:0]     poll_addr_q, poll_addr_d;
  logic                            exp_bit_q, exp_bit_d;
  logic                            busy, accept;
  logic [nfcs_pkg::ADDR_W-1:0]     addr;

  assign cmd_i.ready = !full_i;
  assign accept      = cmd_i.valid && !full_i;
  assign push_o      = accept;
  assign addr        = cmd_i.address & AddrMask;
  assign busy        = (phase_q == nfcs_pkg::PH_READ) || (phase_q == nfcs_pkg::PH_POLL);

  always_comb begin
    phase_d     = phase_q;
    poll_addr_d = poll_addr_q;
    exp_bit_d   = exp_bit_q;
    desc_o      = '{op: nfcs_pkg::OP_ERROR, addr: '0, data: '0};
    if (cmd_i.mode == nfcs_pkg::MODE_RESPONSE) begin
      unique case (phase_q)
        nfcs_pkg::PH_READ: begin
          desc_o.op   = nfcs_pkg::OP_DONE;
          desc_o.data = cmd_i.read_data;
          phase_d     = nfcs_pkg::PH_IDLE;
        end
        nfcs_pkg::PH_POLL: begin
          if (cmd_i.read_data[7] == exp_bit_q) begin
            desc_o.op = nfcs_pkg::OP_DONE;
            phase_d   = nfcs_pkg::PH_IDLE;
          end else begin
            desc_o.op   = nfcs_pkg::OP_READ;
            desc_o.addr = poll_addr_q;
          end
        end
        default: desc_o.op = nfcs_pkg::OP_ERROR;
      endcase
    end else if (!busy) begin
      unique case (cmd_i.mode)
        nfcs_pkg::MODE_READ: begin
          desc_o.op   = nfcs_pkg::OP_READ;
          desc_o.addr = addr;
          phase_d     = nfcs_pkg::PH_READ;
        end
        nfcs_pkg::MODE_PROGRAM: begin
          desc_o      = '{op: nfcs_pkg::OP_PROGRAM, addr: addr, data: cmd_i.write_data};
          poll_addr_d = addr;
          exp_bit_d   = cmd_i.write_data[7];
          phase_d     = nfcs_pkg::PH_POLL;
        end
        nfcs_pkg::MODE_SECTOR: begin
          desc_o.op   = nfcs_pkg::OP_SECTOR;
          desc_o.addr = addr;
          poll_addr_d = addr;
          exp_bit_d   = 1'b1;
          phase_d     = nfcs_pkg::PH_POLL;
        end
        nfcs_pkg::MODE_CHIP: begin
          desc_o.op   = nfcs_pkg::OP_CHIP;
          poll_addr_d = '0;
          exp_bit_d   = 1'b1;
          phase_d     = nfcs_pkg::PH_POLL;
        end
        nfcs_pkg::MODE_ID_ENTRY: desc_o.op = nfcs_pkg::OP_ID_ENTRY;
        nfcs_pkg::MODE_ID_EXIT:  desc_o.op = nfcs_pkg::OP_ID_EXIT;
        default:                 desc_o.op = nfcs_pkg::OP_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= nfcs_pkg::PH_IDLE;
      poll_addr_q <= '0;
      exp_bit_q   <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      poll_addr_q <= poll_addr_d;
      exp_bit_q   <= exp_bit_d;
    end
  end

endmodule

>>> rtl/core/nfcs_queue.sv
// Small register queue of classified operations between the front and back ends.
// Depends on nfcs_pkg.
module nfcs_queue #(
  parameter int Depth = nfcs_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nfcs_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output nfcs_pkg::desc_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  nfcs_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push_en, pop_en;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign push_en      = push_i && !full_o;
  assign pop_en       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_en) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_en) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_en && !pop_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_en && !push_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/nfcs_back.sv
// Back end: expands each queued operation into bus and status words, one word per cycle while the result side is ready.
// Depends on nfcs_pkg and nfcs_rsp_if.
module nfcs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  nfcs_pkg::desc_t head_i,
  output logic            pop_o,
  nfcs_rsp_if.source      rsp_o
);

  logic [nfcs_pkg::STEP_W-1:0] step_q;
  logic                        valid_q;
  nfcs_pkg::res_t              res_q, res_d;
  logic                        last_q, last_d;
  logic                        load;

  assign load   = !valid_q || rsp_o.ready;
  assign res_d  = nfcs_pkg::expand(head_i, step_q);
  assign last_d = (step_q == nfcs_pkg::op_len(head_i.op) - 1'b1);
  assign pop_o  = load && head_valid_i && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else if (load) begin
      valid_q <= head_valid_i;
      if (head_valid_i) begin
        step_q <= last_d ? '0 : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      res_q  <= res_d;
      last_q <= last_d;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.kind        = res_q.kind;
  assign rsp_o.bus_address = res_q.addr;
  assign rsp_o.bus_data    = res_q.bus_data;
  assign rsp_o.result_data = res_q.result_data;
  assign rsp_o.last        = last_q;

endmodule

>>> rtl/core/nor_flash_command_sequencer_core.sv
// NOR flash command sequencer top level: front end, operation queue and back end.
// The first result word of a command is held in the operation queue and then in the back end output register.
// Throughput: a command is accepted every cycle while the operation queue has room; the back
// end sends one word per cycle while the result side is ready, and a command makes 1 to 7 words.
// Reset (asynchronous, active low) returns to idle with nothing pending and empties the queue.
module nor_flash_command_sequencer_core #(
  parameter int AddrBits   = nfcs_pkg::ADDR_BITS,
  parameter int QueueDepth = nfcs_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nfcs_cmd_if.sink   cmd_i,
  nfcs_rsp_if.source rsp_o
);

  // Classified operations travel from the front end to the back end.
  logic            push, full, pop, head_valid;
  nfcs_pkg::desc_t push_desc, head;

  // The front end owns the pending read and poll state, so every command is judged
  // as soon as it is accepted, independent of how far behind the output is.
  nfcs_front #(
    .AddrBits(AddrBits)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .desc_o (push_desc)
  );

  // The queue lets the command side keep going while the result side is stalled.
  nfcs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The back end walks each operation's words (unlock, program or erase words and, for program
  // and erase, the poll request), then releases the queue entry with the word marked last.
  nfcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

endmodule
